>>> hdl/det_pkg.sv
// ----------------------------------------------------------------------------
// det_pkg
// Shared types and constants for the deadline event table.
// ----------------------------------------------------------------------------
package det_pkg;

    localparam int SLOTS     = 16;
    localparam int MAX_FIRES = 16;
    localparam int SLOT_W    = 4;
    localparam int TIME_W    = 64;
    localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int FIRE_W    = $clog2(MAX_FIRES + 1);

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [FIRE_W-1:0] fire_cnt_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [TIME_W-1:0] time_t;

    typedef enum logic [1:0] {
        ACT_REGISTER   = 2'd0,
        ACT_UNREGISTER = 2'd1,
        ACT_SCHEDULE   = 2'd2,
        ACT_TICK       = 2'd3
    } action_t;

    typedef struct packed {
        action_t action;
        slot_t   slot;
        logic    has_handler;
        time_t   time_req;
    } cmd_t;

    typedef struct packed {
        slot_t fired_slot;
        time_t fired_time;
        logic  last;
    } result_t;

    typedef struct packed {
        logic  fire;
        logic  flush;
        slot_t slot;
        time_t deadline;
    } emit_ctrl_t;

endpackage

>>> hdl/det_ram.sv
// ----------------------------------------------------------------------------
// det_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module det_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/det_emit.sv
// ----------------------------------------------------------------------------
// det_emit
// Holds one firing back so that the final firing of a tick can be flagged.
// ----------------------------------------------------------------------------
module det_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  det_pkg::emit_ctrl_t ctrl,
    output logic                strobe,
    output det_pkg::result_t    result
);

    logic             pend_valid_reg, pend_valid_next;
    det_pkg::slot_t   pend_slot_reg, pend_slot_next;
    det_pkg::time_t   pend_time_reg, pend_time_next;
    logic             strobe_reg, strobe_next;
    det_pkg::result_t result_reg, result_next;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_time_next  = pend_time_reg;
        strobe_next     = 1'b0;
        result_next     = result_reg;
        if (ctrl.fire)
        begin
            if (pend_valid_reg)
            begin
                strobe_next            = 1'b1;
                result_next.fired_slot = pend_slot_reg;
                result_next.fired_time = pend_time_reg;
                result_next.last       = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_slot_next  = ctrl.slot;
            pend_time_next  = ctrl.deadline;
        end
        else if (ctrl.flush && pend_valid_reg)
        begin
            strobe_next            = 1'b1;
            result_next.fired_slot = pend_slot_reg;
            result_next.fired_time = pend_time_reg;
            result_next.last       = 1'b1;
            pend_valid_next        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_slot_reg <= pend_slot_next;
        pend_time_reg <= pend_time_next;
        result_reg    <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

>>> hdl/deadline_event_table_core.sv
// ----------------------------------------------------------------------------
// deadline_event_table_core
// Event slot table kept in registration order, with deadline expiry on tick.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Register and schedule
// complete in the cycle of their transfer and leave busy low, as do an
// unregister of a slot that is not a member and a tick while there are no
// members. An unregister of a member compacts the order list and holds busy,
// and a tick with members holds busy too: both walk the order memory at one
// entry per cycle through its single read port, and a tick then reads each
// member's deadline from the deadline memory. Firings appear in member order,
// one per strobe, the last of a tick with last set; the final firing is shown
// in the first cycle in which busy is low again. Results cannot be held off
// and must be taken in the cycle they are shown.
module deadline_event_table_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  det_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             strobe,
    output det_pkg::result_t result
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_TICK  = 3'b010,
        ST_UNREG = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    det_pkg::cnt_t            len_reg, len_next;
    logic [det_pkg::SLOTS-1:0] member_reg, member_next;
    logic [det_pkg::SLOTS-1:0] armed_reg, armed_next;
    logic [det_pkg::SLOTS-1:0] handler_reg, handler_next;
    det_pkg::cnt_t            idx_reg, idx_next;
    logic                     s1_valid_reg, s1_valid_next;
    logic                     s2_valid_reg, s2_valid_next;
    logic                     found_reg, found_next;
    det_pkg::fire_cnt_t       fire_cnt_reg, fire_cnt_next;
    det_pkg::idx_t            s1_idx_reg, s1_idx_next;
    det_pkg::slot_t           s2_slot_reg, s2_slot_next;
    det_pkg::slot_t           uslot_reg, uslot_next;
    det_pkg::time_t           now_reg, now_next;

    logic                 order_we;
    det_pkg::idx_t        order_waddr;
    det_pkg::slot_t       order_wdata;
    det_pkg::idx_t        order_raddr;
    det_pkg::slot_t       order_rdata;
    logic                 dl_we;
    det_pkg::idx_t        dl_waddr;
    det_pkg::time_t       dl_wdata;
    det_pkg::idx_t        dl_raddr;
    det_pkg::time_t       dl_rdata;
    det_pkg::emit_ctrl_t  emit_ctrl;
    det_pkg::idx_t        cmd_ix;
    det_pkg::idx_t        s2_ix;
    logic                 in_range;

    assign cmd_ix   = det_pkg::idx_t'(cmd.slot);
    assign s2_ix    = det_pkg::idx_t'(s2_slot_reg);
    assign in_range = (32'(cmd.slot) < 32'(det_pkg::SLOTS));
    assign busy     = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        len_next      = len_reg;
        member_next   = member_reg;
        armed_next    = armed_reg;
        handler_next  = handler_reg;
        idx_next      = idx_reg;
        s1_valid_next = 1'b0;
        s2_valid_next = 1'b0;
        found_next    = found_reg;
        fire_cnt_next = fire_cnt_reg;
        s1_idx_next   = s1_idx_reg;
        s2_slot_next  = s2_slot_reg;
        uslot_next    = uslot_reg;
        now_next      = now_reg;
        order_we      = 1'b0;
        order_waddr   = '0;
        order_wdata   = '0;
        order_raddr   = idx_reg[det_pkg::IDX_W-1:0];
        dl_we         = 1'b0;
        dl_waddr      = cmd_ix;
        dl_wdata      = '0;
        dl_raddr      = det_pkg::idx_t'(order_rdata);
        emit_ctrl     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.action)
                        det_pkg::ACT_REGISTER:
                        begin
                            if (in_range)
                            begin
                                if (member_reg[cmd_ix])
                                begin
                                    handler_next[cmd_ix] = cmd.has_handler;
                                end
                                else if (len_reg < det_pkg::cnt_t'(det_pkg::SLOTS))
                                begin
                                    order_we             = 1'b1;
                                    order_waddr          = len_reg[det_pkg::IDX_W-1:0];
                                    order_wdata          = cmd.slot;
                                    dl_we                = 1'b1;
                                    dl_wdata             = '0;
                                    armed_next[cmd_ix]   = 1'b0;
                                    handler_next[cmd_ix] = cmd.has_handler;
                                    member_next[cmd_ix]  = 1'b1;
                                    len_next             = len_reg + 1'b1;
                                end
                            end
                        end
                        det_pkg::ACT_UNREGISTER:
                        begin
                            if (in_range && member_reg[cmd_ix])
                            begin
                                member_next[cmd_ix] = 1'b0;
                                armed_next[cmd_ix]  = 1'b0;
                                uslot_next          = cmd.slot;
                                found_next          = 1'b0;
                                idx_next            = '0;
                                state_next          = ST_UNREG;
                            end
                        end
                        det_pkg::ACT_SCHEDULE:
                        begin
                            if (in_range)
                            begin
                                dl_we              = 1'b1;
                                dl_wdata           = cmd.time_req;
                                armed_next[cmd_ix] = 1'b1;
                            end
                        end
                        det_pkg::ACT_TICK:
                        begin
                            if (len_reg != '0)
                            begin
                                now_next      = cmd.time_req;
                                idx_next      = '0;
                                fire_cnt_next = '0;
                                state_next    = ST_TICK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TICK:
            begin
                if (idx_reg < len_reg)
                begin
                    s1_valid_next = 1'b1;
                    s1_idx_next   = idx_reg[det_pkg::IDX_W-1:0];
                    idx_next      = idx_reg + 1'b1;
                end
                if (s1_valid_reg)
                begin
                    s2_valid_next = 1'b1;
                    s2_slot_next  = order_rdata;
                end
                if (s2_valid_reg && armed_reg[s2_ix] && (dl_rdata <= now_reg))
                begin
                    if (handler_reg[s2_ix])
                    begin
                        if (fire_cnt_reg < det_pkg::fire_cnt_t'(det_pkg::MAX_FIRES))
                        begin
                            emit_ctrl.fire     = 1'b1;
                            emit_ctrl.slot     = s2_slot_reg;
                            emit_ctrl.deadline = dl_rdata;
                            fire_cnt_next      = fire_cnt_reg + 1'b1;
                            armed_next[s2_ix]  = 1'b0;
                        end
                    end
                    else
                    begin
                        armed_next[s2_ix] = 1'b0;
                    end
                end
                if ((idx_reg == len_reg) && !s1_valid_reg && !s2_valid_reg)
                begin
                    emit_ctrl.flush = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_UNREG:
            begin
                if (idx_reg < len_reg)
                begin
                    s1_valid_next = 1'b1;
                    s1_idx_next   = idx_reg[det_pkg::IDX_W-1:0];
                    idx_next      = idx_reg + 1'b1;
                end
                if (s1_valid_reg)
                begin
                    if (order_rdata == uslot_reg)
                    begin
                        found_next = 1'b1;
                    end
                    else if (found_reg)
                    begin
                        order_we    = 1'b1;
                        order_waddr = s1_idx_reg - 1'b1;
                        order_wdata = order_rdata;
                    end
                end
                if ((idx_reg == len_reg) && !s1_valid_reg)
                begin
                    len_next   = len_reg - 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            len_reg      <= '0;
            member_reg   <= '0;
            armed_reg    <= '0;
            handler_reg  <= '0;
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            fire_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            member_reg   <= member_next;
            armed_reg    <= armed_next;
            handler_reg  <= handler_next;
            idx_reg      <= idx_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            found_reg    <= found_next;
            fire_cnt_reg <= fire_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= s1_idx_next;
        s2_slot_reg <= s2_slot_next;
        uslot_reg   <= uslot_next;
        now_reg     <= now_next;
    end

    det_ram #(
        .WIDTH (det_pkg::SLOT_W),
        .DEPTH (det_pkg::SLOTS)
    ) u_order_ram (
        .clk   (clk),
        .we    (order_we),
        .waddr (order_waddr),
        .wdata (order_wdata),
        .raddr (order_raddr),
        .rdata (order_rdata)
    );

    det_ram #(
        .WIDTH (det_pkg::TIME_W),
        .DEPTH (det_pkg::SLOTS)
    ) u_deadline_ram (
        .clk   (clk),
        .we    (dl_we),
        .waddr (dl_waddr),
        .wdata (dl_wdata),
        .raddr (dl_raddr),
        .rdata (dl_rdata)
    );

    det_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (emit_ctrl),
        .strobe (strobe),
        .result (result)
    );

endmodule
